// File: sv/bhcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bhcd_pkg;

	localparam int ADC_W    = 12;
	localparam int HALL_W   = 3;
	localparam int GATE_W   = 6;
	localparam int CMP_W    = 16;
	localparam int DUTY_W   = 7;
	localparam int PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd9375;

	// Hall codes that never occur on a healthy sensor set
	localparam logic [HALL_W-1:0] HALL_BAD_LO = 3'd3;
	localparam logic [HALL_W-1:0] HALL_BAD_HI = 3'd4;

	// |2*adc - 4095| below this is inside the dead zone (|demand| < 2)
	localparam logic [ADC_W-1:0] DEAD_ZONE_MAG = 12'd91;
	localparam logic [ADC_W:0]   ADC_FULL      = 13'd4095;

	// duty = floor(2m/91) = (2m * DUTY_RECIP) >> DUTY_SHIFT, exact for 2m < 61680
	localparam int               DUTY_SHIFT = 20;
	localparam logic [13:0]      DUTY_RECIP = 14'd11523;

	// floor(p/100) = ((p >> 2) * PCT_RECIP) >> PCT_SHIFT, exact for p < 5898151
	localparam int               PCT_SHIFT = 24;
	localparam logic [19:0]      PCT_RECIP = 20'd671089;

	localparam logic [GATE_W-1:0] FWD_GATES [8] = '{
		6'h21, 6'h09, 6'h24, 6'h00, 6'h00, 6'h18, 6'h06, 6'h12
	};
	localparam logic [GATE_W-1:0] REV_GATES [8] = '{
		6'h18, 6'h12, 6'h09, 6'h00, 6'h00, 6'h06, 6'h21, 6'h24
	};

	typedef struct packed {
		logic [ADC_W-1:0] adc_sample;
		logic             hall_a;
		logic             hall_b;
		logic             hall_c;
	} sample_t;

	typedef struct packed {
		logic [GATE_W-1:0] gate_pattern;
		logic [CMP_W-1:0]  cmp_phase1_high;
		logic [CMP_W-1:0]  cmp_phase1_low;
		logic [CMP_W-1:0]  cmp_phase2_high;
		logic [CMP_W-1:0]  cmp_phase2_low;
		logic [CMP_W-1:0]  cmp_phase3_high;
		logic [CMP_W-1:0]  cmp_phase3_low;
		logic [DUTY_W-1:0] duty_percent;
	} result_t;

	typedef struct packed {
		logic load_in;
		logic do_duty;
		logic do_scale;
		logic do_cmp;
		logic cfg_wr;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

// File: sv/bhcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bhcd_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sample_valid,
	output logic                sample_stall,
	output logic                result_valid,
	input  wire                 result_stall,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	output bhcd_pkg::ctrl_cmd_t cmd
);
	import bhcd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DUTY  = 4'b0010,
		ST_SCALE = 4'b0100,
		ST_CMP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign cfg_ready    = 1'b1;

	always_comb begin
		cmd          = '0;
		cmd.cfg_wr   = cfg_valid;
		cmd.load_in  = (state_q == ST_IDLE) && sample_valid;
		cmd.do_duty  = (state_q == ST_DUTY);
		cmd.do_scale = (state_q == ST_SCALE);
		cmd.do_cmp   = (state_q == ST_CMP) && out_free;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (sample_valid) state_nxt = ST_DUTY;
			ST_DUTY:  state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_CMP;
			// hold the finished request until the output register frees up
			ST_CMP:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.do_cmp) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> state_q == ST_DUTY)
		else $error("accepted request did not start the duty step");
	a_duty_to_scale: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUTY |=> state_q == ST_SCALE)
		else $error("duty step not followed by scale step");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_cmp |=> result_valid_q)
		else $error("loaded result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_cmp |-> (!result_valid_q || !result_stall))
		else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

// File: sv/bhcd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bhcd_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bhcd_pkg::ctrl_cmd_t   cmd,
	input  bhcd_pkg::sample_t     sample,
	input  wire [15:0]            cfg_data,
	output bhcd_pkg::result_t     result
);
	import bhcd_pkg::*;

	logic [ADC_W-1:0]    adc_q;
	logic [HALL_W-1:0]   hall_q;
	logic [PERIOD_W-1:0] period_q;
	logic [GATE_W-1:0]   held_q;
	logic [GATE_W-1:0]   gates_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [22:0]         prod_q;
	result_t             result_q;

	// duty step
	logic              forward;
	logic [ADC_W:0]    two_adc;
	logic [ADC_W-1:0]  mag;
	logic [ADC_W:0]    mag2;
	logic [26:0]       duty_prod;
	logic [GATE_W-1:0] gates_sel;
	logic [GATE_W-1:0] gates_nxt;

	// compare step
	logic [20:0]    pct_in;
	logic [40:0]    pct_prod;
	logic [CMP_W-1:0] cmp;

	always_comb begin
		two_adc   = {adc_q, 1'b0};
		forward   = adc_q[ADC_W-1];
		mag       = forward ? ADC_W'(two_adc - ADC_FULL) : ADC_W'(ADC_FULL - two_adc);
		mag2      = {mag, 1'b0};
		duty_prod = 27'(mag2 * DUTY_RECIP);
		if (hall_q == HALL_BAD_LO || hall_q == HALL_BAD_HI) begin
			gates_sel = held_q;
		end else begin
			gates_sel = forward ? FWD_GATES[hall_q] : REV_GATES[hall_q];
		end
		gates_nxt = (mag < DEAD_ZONE_MAG) ? '0 : gates_sel;
	end

	always_comb begin
		pct_in   = prod_q[22:2];
		pct_prod = 41'(pct_in * PCT_RECIP);
		cmp      = CMP_W'(pct_prod[40:PCT_SHIFT]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			held_q   <= '0;
		end else begin
			if (cmd.cfg_wr) period_q <= cfg_data;
			if (cmd.do_duty) held_q <= gates_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			adc_q  <= sample.adc_sample;
			hall_q <= {sample.hall_c, sample.hall_b, sample.hall_a};
		end
		if (cmd.do_duty) begin
			gates_q <= gates_nxt;
			duty_q  <= DUTY_W'(duty_prod[26:DUTY_SHIFT]);
		end
		if (cmd.do_scale) begin
			prod_q <= 23'(period_q * duty_q);
		end
		if (cmd.do_cmp) begin
			result_q.gate_pattern    <= gates_q;
			result_q.cmp_phase1_high <= gates_q[0] ? cmp : '0;
			result_q.cmp_phase1_low  <= gates_q[1] ? cmp : '0;
			result_q.cmp_phase2_high <= gates_q[2] ? cmp : '0;
			result_q.cmp_phase2_low  <= gates_q[3] ? cmp : '0;
			result_q.cmp_phase3_high <= gates_q[4] ? cmp : '0;
			result_q.cmp_phase3_low  <= gates_q[5] ? cmp : '0;
			result_q.duty_percent    <= duty_q;
		end
	end

	assign result = result_q;

`ifndef ASSERT_OFF
	a_dead_zone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_scale |-> (duty_q >= 7'd2 || gates_q == '0))
		else $error("gates driven inside the dead zone");
	a_held_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_scale |-> held_q == gates_q)
		else $error("held pattern differs from current pattern");
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_scale |-> duty_q <= 7'd90)
		else $error("duty above ninety percent");
`endif

endmodule
`default_nettype wire

// File: sv/bldc_hall_commutation_duty_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Six-step Hall commutation with torque-proportional duty. Each request
// carries a 12-bit converter sample (midscale is zero demand) and the three
// Hall levels; each produces one result: the six gate enables, six compare
// values floor(period*duty/100) for enabled gates, and the duty in percent
// (0..90). Hall codes 3 and 4 repeat the previous pattern; a demand below 2%
// turns all gates off. A request is accepted in the idle state and then passes
// through the three multiply steps of the datapath (duty, period scale,
// percent) in the states DUTY, SCALE and CMP; the last of them loads the
// output register. The last step waits while a stalled result still holds
// the output register. The next request is taken once the block returns to
// idle, while the previous result may still wait in the output register.
// The period register (reset 9375) is written through the cfg channel,
// which is always ready; write it only while no request is open.
module bldc_hall_commutation_duty_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                sample_valid,
	output logic               sample_stall,
	input  bhcd_pkg::sample_t  sample,
	output logic               result_valid,
	input  wire                result_stall,
	output bhcd_pkg::result_t  result,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [15:0]         cfg_data
);
	import bhcd_pkg::*;

	ctrl_cmd_t cmd;

	bhcd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd)
	);

	bhcd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (sample),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule
`default_nettype wire

// File: tb/duty_check_pkg.sv
`timescale 1ns / 1ps
package duty_check_pkg;

	import bhcd_pkg::*;

	localparam int ADC_GAIN       = 180;
	localparam int ADC_OFFSET     = 368550;
	localparam int ADC_SPAN       = 4095;
	localparam int DEAD_BAND_NUM  = 8190;
	localparam int DUTY_LIMIT     = 90;
	localparam int PERCENT_SCALE  = 100;

	localparam logic [GATE_W-1:0] FWD_STEP_GATES [8] = '{
		6'h21, 6'h09, 6'h24, 6'h00, 6'h00, 6'h18, 6'h06, 6'h12
	};
	localparam logic [GATE_W-1:0] REV_STEP_GATES [8] = '{
		6'h18, 6'h12, 6'h09, 6'h00, 6'h00, 6'h06, 6'h21, 6'h24
	};

	class commutation_scoreboard;
		logic [PERIOD_W-1:0] period;
		logic [GATE_W-1:0]   held_gates;
		result_t             pending_results[$];
		int unsigned         failures;
		int unsigned         checked;
		int unsigned         dead_zone_hits;
		int unsigned         held_hits;

		function new();
			period = PERIOD_RESET;
			held_gates = '0;
			failures = 0;
			checked = 0;
			dead_zone_hits = 0;
			held_hits = 0;
		endfunction

		function result_t predict_commutation(sample_t s);
			int              demand_num;
			bit              forward;
			int unsigned     mag;
			int unsigned     duty;
			int unsigned     scaled;
			logic [2:0]      code;
			logic [GATE_W-1:0] gates;
			result_t         r;
			demand_num = ADC_GAIN * int'(s.adc_sample) - ADC_OFFSET;
			forward = demand_num > 0;
			mag = (demand_num < 0) ? -demand_num : demand_num;
			duty = mag / ADC_SPAN;
			if (duty > DUTY_LIMIT)
				duty = DUTY_LIMIT;
			code = {s.hall_c, s.hall_b, s.hall_a};
			if (code == HALL_BAD_LO || code == HALL_BAD_HI) begin
				gates = held_gates;
				held_hits++;
			end else begin
				gates = forward ? FWD_STEP_GATES[code] : REV_STEP_GATES[code];
			end
			// force all gates off below 2 percent demand; that zero is what gets held
			if (mag < DEAD_BAND_NUM) begin
				gates = '0;
				dead_zone_hits++;
			end
			held_gates = gates;
			scaled = (32'(period) * duty) / PERCENT_SCALE;
			r.gate_pattern    = gates;
			r.cmp_phase1_high = gates[0] ? scaled[CMP_W-1:0] : '0;
			r.cmp_phase1_low  = gates[1] ? scaled[CMP_W-1:0] : '0;
			r.cmp_phase2_high = gates[2] ? scaled[CMP_W-1:0] : '0;
			r.cmp_phase2_low  = gates[3] ? scaled[CMP_W-1:0] : '0;
			r.cmp_phase3_high = gates[4] ? scaled[CMP_W-1:0] : '0;
			r.cmp_phase3_low  = gates[5] ? scaled[CMP_W-1:0] : '0;
			r.duty_percent    = duty[DUTY_W-1:0];
			return r;
		endfunction

		function void note_sample(sample_t s);
			pending_results.push_back(predict_commutation(s));
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				failures++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("gate_pattern", want.gate_pattern, got.gate_pattern);
			compare_field("cmp_phase1_high", want.cmp_phase1_high, got.cmp_phase1_high);
			compare_field("cmp_phase1_low", want.cmp_phase1_low, got.cmp_phase1_low);
			compare_field("cmp_phase2_high", want.cmp_phase2_high, got.cmp_phase2_high);
			compare_field("cmp_phase2_low", want.cmp_phase2_low, got.cmp_phase2_low);
			compare_field("cmp_phase3_high", want.cmp_phase3_high, got.cmp_phase3_high);
			compare_field("cmp_phase3_low", want.cmp_phase3_low, got.cmp_phase3_low);
			compare_field("duty_percent", want.duty_percent, got.duty_percent);
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	import bhcd_pkg::*;
	import duty_check_pkg::*;

	localparam int QUIET_LIMIT    = 2000;
	localparam int PHASE_REQUESTS = 115;
	localparam int NUM_PHASES     = 7;
	localparam int QUIET_PHASE    = 2;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data = '0;

	commutation_scoreboard sb;
	bit                  tx_idle_en = 1'b1;
	bit                  rx_idle_en = 1'b1;
	int unsigned         quiet_cycles = 0;
	int unsigned         periods_used = 1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bldc_hall_commutation_duty_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		result_stall <= rx_idle_en ? ($urandom_range(99) < 25) : 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("bldc_hall_commutation_duty_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_sample(input sample_t s);
		while (tx_idle_en && $urandom_range(99) < 25) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		sb.note_sample(s);
	endtask

	// hold the sender until every outstanding request has its result
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.period = value;
		periods_used++;
	endtask

	function automatic sample_t make_sample(int adc, logic [2:0] code);
		sample_t s;
		s.adc_sample = adc[ADC_W-1:0];
		{s.hall_c, s.hall_b, s.hall_a} = code;
		return s;
	endfunction

	function automatic sample_t random_sample();
		int         pick;
		int         adc;
		logic [2:0] code;
		pick = $urandom_range(99);
		if (pick < 30)
			adc = $urandom_range(2105, 1990);
		else if (pick < 40)
			adc = $urandom_range(1) ? $urandom_range(5, 0) : $urandom_range(4095, 4090);
		else
			adc = $urandom_range(4095, 0);
		pick = $urandom_range(99);
		if (pick < 10) begin
			code = HALL_BAD_LO;
		end else if (pick < 20) begin
			code = HALL_BAD_HI;
		end else begin
			do code = 3'($urandom_range(7)); while (code == HALL_BAD_LO || code == HALL_BAD_HI);
		end
		return make_sample(adc, code);
	endfunction

	initial begin
		logic [PERIOD_W-1:0] phase_period [NUM_PHASES];
		sb = new();
		phase_period = '{16'd65535, 16'd0, 16'd1, 16'd0, PERIOD_RESET, 16'd100, 16'd0};
		phase_period[3] = PERIOD_W'($urandom_range(65535));
		phase_period[6] = PERIOD_W'($urandom_range(65535));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full forward then full reverse demand over every hall code
		for (int c = 0; c < 8; c++)
			send_sample(make_sample(4095, c[2:0]));
		for (int c = 0; c < 8; c++)
			send_sample(make_sample(0, c[2:0]));
		// dead-zone edges on both sides, and the midscale pair
		send_sample(make_sample(2093, 3'd1));
		send_sample(make_sample(2092, 3'd1));
		send_sample(make_sample(2092, HALL_BAD_LO));
		send_sample(make_sample(2002, 3'd5));
		send_sample(make_sample(2003, 3'd6));
		send_sample(make_sample(2047, 3'd2));
		send_sample(make_sample(2048, 3'd2));
		send_sample(make_sample(3000, HALL_BAD_HI));
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_period(phase_period[p]);
			tx_idle_en = (p != QUIET_PHASE);
			rx_idle_en = (p != QUIET_PHASE);
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				if (i == PHASE_REQUESTS / 2)
					drain_results();
				send_sample(random_sample());
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("%0d results checked over %0d period settings", sb.checked, periods_used);
		$display("%0d in the dead zone, %0d on an invalid hall code", sb.dead_zone_hits,
			sb.held_hits);
		if (sb.failures == 0 && sb.pending_results.size() == 0) begin
			$display("bldc_hall_commutation_duty_top regression: pass");
		end else begin
			$display("bldc_hall_commutation_duty_top regression: fail");
		end
		$finish;
	end

endmodule
